// ===== src/lblc_pkg.sv =====
// Package for the lane budget limit counter: widths, reset values,
// register indexes, saturating helpers and the controller/datapath structs.
// No dependencies.
`default_nettype none
package lblc_pkg;

	// Field and bus widths
	localparam int DATA_W     = 32;
	localparam int LANE_W     = 2;
	localparam int AL_W       = 3;
	localparam int CFG_ADDR_W = 1;
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 40;
	localparam int M_PAD_W    = M_TDATA_W - DATA_W - 1;

	// Default lane count
	localparam int LANES_DEFAULT = 4;

	// Register reset values
	localparam logic [DATA_W-1:0] LIMIT_RESET  = 32'h8000_0000;
	localparam logic [AL_W-1:0]   ACTIVE_RESET = 3'd3;

	// Register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_COUNT_LIMIT  = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_LANES = 1'd1;

	// Share divider: quotient bits retired per cycle and cycle count
	localparam int DIV_RADIX_BITS = 4;
	localparam int DIV_STEPS      = DATA_W / DIV_RADIX_BITS;
	localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic fast_add;
		logic fold;
		logic head_load;
		logic gadd;
		logic div_init;
		logic div_step;
		logic share;
		logic read_sel;
		logic read_step;
		logic set_acc;
		logic acc_val;
		logic load_out;
	} ctrl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic is_read;
		logic lane_ok;
		logic fits;
		logic hr_short;
		logic div_last;
		logic read_last;
		logic out_free;
	} dp_stat_t;

	// Add that sticks at all ones
	function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
		input logic [DATA_W-1:0] b);
		logic [DATA_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DATA_W] ? {DATA_W{1'b1}} : s[DATA_W-1:0];
	endfunction

	// Subtract that floors at zero
	function automatic logic [DATA_W-1:0] sat_sub(input logic [DATA_W-1:0] a,
		input logic [DATA_W-1:0] b);
		return (a > b) ? (a - b) : '0;
	endfunction

endpackage
`default_nettype wire

// ===== src/lblc_ctrl.sv =====
// Controller FSM for the lane budget limit counter.
// Sequences the datapath through fast add, fold/refill and read.
// Depends on lblc_pkg.
`default_nettype none
module lblc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lblc_pkg::dp_stat_t   stat,
	output lblc_pkg::ctrl_cmd_t  cmd
);
	import lblc_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CHECK = 4'd1;
	localparam logic [3:0] ST_HEAD  = 4'd2;
	localparam logic [3:0] ST_GATE  = 4'd3;
	localparam logic [3:0] ST_DINIT = 4'd4;
	localparam logic [3:0] ST_DIV   = 4'd5;
	localparam logic [3:0] ST_SHARE = 4'd6;
	localparam logic [3:0] ST_READ  = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nx;

	// Next state and command decode
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = ST_CHECK;
				end
			end
			ST_CHECK: begin
				priority if (stat.is_read) begin
					state_nx = ST_READ;
				end else if (!stat.lane_ok) begin
					cmd.set_acc = 1'b1;
					cmd.acc_val = 1'b0;
					state_nx    = ST_DONE;
				end else if (stat.fits) begin
					cmd.fast_add = 1'b1;
					cmd.set_acc  = 1'b1;
					cmd.acc_val  = 1'b1;
					state_nx     = ST_DONE;
				end else begin
					cmd.fold = 1'b1;
					state_nx = ST_HEAD;
				end
			end
			ST_HEAD: begin
				cmd.head_load = 1'b1;
				state_nx      = ST_GATE;
			end
			ST_GATE: begin
				if (stat.hr_short) begin
					cmd.set_acc = 1'b1;
					cmd.acc_val = 1'b0;
					state_nx    = ST_DONE;
				end else begin
					cmd.gadd = 1'b1;
					state_nx = ST_DINIT;
				end
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				state_nx     = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_nx = ST_SHARE;
				end
			end
			ST_SHARE: begin
				cmd.share   = 1'b1;
				cmd.set_acc = 1'b1;
				cmd.acc_val = 1'b1;
				state_nx    = ST_DONE;
			end
			ST_READ: begin
				cmd.read_sel  = 1'b1;
				cmd.read_step = 1'b1;
				if (stat.read_last) begin
					cmd.set_acc = 1'b1;
					cmd.acc_val = 1'b1;
					state_nx    = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule
`default_nettype wire

// ===== src/lblc_dp.sv =====
// Datapath for the lane budget limit counter: config registers, lane and
// global counters, share divider, read accumulator and result register.
// Depends on lblc_pkg.
`default_nettype none
module lblc_dp #(
	parameter int LANES = lblc_pkg::LANES_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lblc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [lblc_pkg::DATA_W-1:0]       cfg_data,
	input  logic                              in_op,
	input  logic [lblc_pkg::LANE_W-1:0]       in_lane,
	input  logic [lblc_pkg::DATA_W-1:0]       in_delta,
	input  lblc_pkg::ctrl_cmd_t               cmd,
	output lblc_pkg::dp_stat_t                stat,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic                              out_accepted,
	output logic [lblc_pkg::DATA_W-1:0]       out_total
);
	import lblc_pkg::*;

	localparam int IDX_W  = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int LCMP_W = ((IDX_W > LANE_W) ? IDX_W : LANE_W) + 1;

	// Configuration
	logic [DATA_W-1:0] count_limit_q;
	logic [AL_W-1:0]   active_lanes_q;

	// Counter state
	logic [DATA_W-1:0] lane_count_q  [LANES];
	logic [DATA_W-1:0] lane_budget_q [LANES];
	logic [DATA_W-1:0] gtot_q;
	logic [DATA_W-1:0] gres_q;

	// Per-transaction working registers
	logic              op_q;
	logic [LANE_W-1:0] lane_q;
	logic [DATA_W-1:0] delta_q;
	logic [DATA_W-1:0] hr_q;
	logic [DATA_W-1:0] quo_q;
	logic [AL_W-1:0]   rem_q;
	logic [DIV_CNT_W-1:0] dcnt_q;
	logic [IDX_W-1:0]  idx_q;
	logic [DATA_W-1:0] sum_q;
	logic              acc_q;

	// Result register
	logic              out_valid_q;
	logic              out_acc_q;
	logic [DATA_W-1:0] out_total_q;

	logic [IDX_W-1:0]  lane_ix;
	logic [IDX_W-1:0]  rd_idx;
	logic [DATA_W-1:0] cnt_sel;
	logic [DATA_W-1:0] bud_sel;
	logic [DATA_W-1:0] room;
	logic [DATA_W-1:0] headroom;
	logic [AL_W-1:0]   divisor;
	logic [DATA_W-1:0] q_nx;
	logic [AL_W-1:0]   r_nx;
	logic [AL_W:0]     trial;
	logic [DATA_W-1:0] half_share;
	logic [DATA_W-1:0] pre;
	logic              out_free;

	// Single lane read port: read sweep index or transaction lane
	assign lane_ix  = IDX_W'(lane_q);
	assign rd_idx   = cmd.read_sel ? idx_q : lane_ix;
	assign cnt_sel  = lane_count_q[rd_idx];
	assign bud_sel  = lane_budget_q[rd_idx];
	assign room     = sat_sub(bud_sel, cnt_sel);
	assign headroom = sat_sub(sat_sub(count_limit_q, gtot_q), gres_q);
	assign divisor  = (active_lanes_q == '0) ? AL_W'(1) : active_lanes_q;

	// Pre-charge: half the share, no more than the global count
	assign half_share = quo_q >> 1;
	assign pre        = (half_share > gtot_q) ? gtot_q : half_share;

	// Restoring divide, DIV_RADIX_BITS quotient bits per cycle
	always_comb begin
		q_nx  = quo_q;
		r_nx  = rem_q;
		trial = '0;
		for (int k = 0; k < DIV_RADIX_BITS; k++) begin
			trial = {r_nx, q_nx[DATA_W-1]};
			q_nx  = {q_nx[DATA_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				r_nx    = AL_W'(trial - {1'b0, divisor});
				q_nx[0] = 1'b1;
			end else begin
				r_nx = trial[AL_W-1:0];
			end
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// Status to controller
	always_comb begin
		stat           = '0;
		stat.is_read   = op_q;
		stat.lane_ok   = (LCMP_W'(lane_q) < LCMP_W'(LANES));
		stat.fits      = (room >= delta_q);
		stat.hr_short  = (hr_q < delta_q);
		stat.div_last  = (dcnt_q == DIV_CNT_W'(DIV_STEPS - 1));
		stat.read_last = (idx_q == IDX_W'(LANES - 1));
		stat.out_free  = out_free;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_limit_q  <= LIMIT_RESET;
			active_lanes_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_COUNT_LIMIT:  count_limit_q  <= cfg_data;
				REG_ACTIVE_LANES: active_lanes_q <= cfg_data[AL_W-1:0];
				default: ;
			endcase
		end
	end

	// Lane and global counter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				lane_count_q[i]  <= '0;
				lane_budget_q[i] <= '0;
			end
			gtot_q <= '0;
			gres_q <= '0;
		end else begin
			priority if (cmd.fast_add) begin
				lane_count_q[lane_ix] <= cnt_sel + delta_q;
			end else if (cmd.fold) begin
				gtot_q                 <= sat_add(gtot_q, cnt_sel);
				gres_q                 <= sat_sub(gres_q, bud_sel);
				lane_count_q[lane_ix]  <= '0;
				lane_budget_q[lane_ix] <= '0;
			end else if (cmd.gadd) begin
				gtot_q <= sat_add(gtot_q, delta_q);
			end else if (cmd.share) begin
				lane_budget_q[lane_ix] <= quo_q;
				gres_q                 <= sat_add(gres_q, quo_q);
				lane_count_q[lane_ix]  <= pre;
				gtot_q                 <= gtot_q - pre;
			end else begin
				gtot_q <= gtot_q;
			end
		end
	end

	// Sequencing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.div_init) begin
				dcnt_q <= '0;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + DIV_CNT_W'(1);
			end
			if (cmd.capture) begin
				idx_q <= '0;
			end else if (cmd.read_step) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// Transaction payload, headroom, divider and read sum
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= in_op;
			lane_q  <= in_lane;
			delta_q <= in_delta;
			sum_q   <= gtot_q;
		end else if (cmd.read_step) begin
			sum_q <= sat_add(sum_q, cnt_sel);
		end
		if (cmd.head_load) begin
			hr_q <= headroom;
		end
		if (cmd.div_init) begin
			quo_q <= headroom;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= q_nx;
			rem_q <= r_nx;
		end
		if (cmd.set_acc) begin
			acc_q <= cmd.acc_val;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_acc_q   <= acc_q;
			out_total_q <= op_q ? sum_q : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_accepted = out_acc_q;
	assign out_total    = out_total_q;

endmodule
`default_nettype wire

// ===== src/lane_budget_limit_counter_unit.sv =====
// Top level of the lane budget limit counter: stream ports, config port,
// controller and datapath. Depends on lblc_pkg, lblc_ctrl, lblc_dp.
//
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tuser: operation; tdata: lane, delta
// m_*       out        m_tvalid/m_tready  tdata: accepted, total
// cfg_*     in         cfg_we             cfg_addr index, cfg_data value
//
// One transaction at a time. An add within the lane budget goes from accept
// through the check state to the result. An add that refills the lane folds it,
// gates on the headroom and runs the share divider (4 quotient bits per cycle).
// A read sums one lane counter per cycle. The result register frees the controller once
// loaded; a stalled m_tready holds the next result in its final state.
// Reset is asynchronous and clears all counters and restores config defaults.
`default_nettype none
module lane_budget_limit_counter_unit #(
	parameter int LANES = lblc_pkg::LANES_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lblc_pkg::S_TDATA_W-1:0]    s_tdata,   // lane[1:0], delta[33:2]
	input  logic                              s_tuser,   // operation[0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lblc_pkg::M_TDATA_W-1:0]    m_tdata,   // accepted[0], total[32:1]
	input  logic                              cfg_we,
	input  logic [lblc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [lblc_pkg::DATA_W-1:0]       cfg_data
);
	import lblc_pkg::*;

	ctrl_cmd_t         cmd;
	dp_stat_t          stat;
	logic              out_accepted;
	logic [DATA_W-1:0] out_total;

	lblc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lblc_dp #(
		.LANES (LANES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.in_op        (s_tuser),
		.in_lane      (s_tdata[LANE_W-1:0]),
		.in_delta     (s_tdata[LANE_W+DATA_W-1:LANE_W]),
		.cmd          (cmd),
		.stat         (stat),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_accepted (out_accepted),
		.out_total    (out_total)
	);

	// Result packing
	assign m_tdata = {{M_PAD_W{1'b0}}, out_total, out_accepted};

endmodule
`default_nettype wire

// ===== src/lblc_checker.sv =====
// Port-level checker for lane_budget_limit_counter_unit, bound to the top.
// Depends on lblc_pkg.
`default_nettype none
module lblc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [lblc_pkg::M_TDATA_W-1:0] m_tdata
);
	import lblc_pkg::*;

	// One transaction in flight: input closes right after an accept
	a_single_txn: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready again right after an accept");

	// No result can appear the cycle after an accept
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
		else $error("result appeared too early");

	// A nonzero total only comes from a read, which is always accepted
	a_total_read: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[DATA_W:1] != '0)) |-> m_tdata[0])
		else $error("nonzero total with accepted low");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind lane_budget_limit_counter_unit lblc_checker u_lblc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// ===== dv/lane_budget_limit_counter_unit_tb.sv =====
// Testbench for lane_budget_limit_counter_unit: a directed table, then random
// adds and reads over several limit/lane settings, checked against a predictor.
// Depends on lblc_pkg and the RTL of the unit only.
`timescale 1ns / 100ps
`default_nettype none
module lane_budget_limit_counter_unit_tb;
	import lblc_pkg::*;

	localparam int          NUM_LANES    = 4;
	localparam logic        OP_ADD       = 1'b0;
	localparam logic        OP_READ      = 1'b1;
	localparam int          IDLE_LIMIT   = 3000;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          SETTLE       = 24;
	localparam int          PHASES       = 8;
	localparam int          PHASE_ITEMS  = 200;
	localparam int          DIRECTED_N   = 26;
	localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        accepted;
		logic [31:0] total;
	} result_t;

	typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

	typedef struct {
		row_kind_t                kind;
		logic [CFG_ADDR_W-1:0]    addr;
		logic                     op;
		logic [LANE_W-1:0]        lane;
		logic [31:0]              value;
		bit                       has_exp;
		bit                       exp_acc;
		logic [31:0]              exp_total;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // lane[1:0], delta[33:2]
	logic s_tuser;                   // operation[0]
	logic m_tvalid;
	logic m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // accepted[0], total[32:1]
	logic cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [DATA_W-1:0] cfg_data;

	// Predictor state and configuration copy
	logic [31:0] lim;
	logic [2:0]  div_lanes;
	logic [31:0] lane_cnt [NUM_LANES];
	logic [31:0] lane_bud [NUM_LANES];
	logic [31:0] g_total;
	logic [31:0] g_resv;

	result_t pending_results[$];
	int mismatches = 0;
	int n_items = 0;
	int n_reads = 0;
	int n_fast = 0;
	int n_refill = 0;
	int n_reject = 0;
	int n_results = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	bit held = 0;
	row_t directed_rows [DIRECTED_N];

	lane_budget_limit_counter_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] clamp_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? ALL_ONES : s[31:0];
	endfunction

	function automatic logic [31:0] floor_sub(input logic [31:0] a, input logic [31:0] b);
		return (a > b) ? a - b : 32'd0;
	endfunction

	function automatic logic [31:0] free_room();
		return floor_sub(floor_sub(lim, g_total), g_resv);
	endfunction

	// One transaction through the predictor; updates the shadow state
	function automatic result_t budget_step(input logic op, input logic [1:0] ln,
		input logic [31:0] d);
		result_t r;
		logic [31:0] sum, div, share, pre;
		r = '0;
		if (op == OP_READ) begin
			sum = g_total;
			for (int i = 0; i < NUM_LANES; i++)
				sum = clamp_add(sum, lane_cnt[i]);
			r.accepted = 1'b1;
			r.total = sum;
			n_reads++;
			return r;
		end
		// fast path: fits in the lane's remaining budget
		if (floor_sub(lane_bud[ln], lane_cnt[ln]) >= d) begin
			lane_cnt[ln] = lane_cnt[ln] + d;
			r.accepted = 1'b1;
			n_fast++;
			return r;
		end
		// fold the lane back into the global pool
		g_total = clamp_add(g_total, lane_cnt[ln]);
		lane_cnt[ln] = '0;
		g_resv = floor_sub(g_resv, lane_bud[ln]);
		lane_bud[ln] = '0;
		if (free_room() < d) begin
			n_reject++;
			return r;
		end
		// count globally, then hand the lane a fresh share, half pre-charged
		g_total = clamp_add(g_total, d);
		div = (div_lanes == 3'd0) ? 32'd1 : {29'd0, div_lanes};
		share = free_room() / div;
		lane_bud[ln] = share;
		g_resv = clamp_add(g_resv, share);
		pre = share / 2;
		if (pre > g_total)
			pre = g_total;
		lane_cnt[ln] = pre;
		g_total = g_total - pre;
		r.accepted = 1'b1;
		n_refill++;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		mismatches++;
		$display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
	endtask

	// Offer one transaction and hold it until taken; expectation queued on accept
	task automatic send_item(input logic op, input logic [1:0] ln, input logic [31:0] d,
		input bit has_exp, input result_t typed);
		result_t r;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(S_TDATA_W-34){1'b0}}, d, ln};
		do @(posedge clk); while (!s_tready);
		r = budget_step(op, ln, d);
		pending_results.push_back(has_exp ? typed : r);
		n_items++;
	endtask

	// Sender bursts with random gaps between them
	task automatic pace();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Register write, only once everything in flight has drained
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_COUNT_LIMIT)
			lim = val;
		else
			div_lanes = val[2:0];
		cfg_we <= 1'b0;
	endtask

	// Random delta, weighted toward small values and the exact budget/headroom edges
	function automatic logic [31:0] pick_delta(input logic [1:0] ln);
		logic [31:0] edge_val;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel <= 4)
			return $urandom_range(0, 64);
		if (sel <= 6)
			return $urandom_range(0, lim >> 2);
		if (sel == 7)
			return $urandom;
		if (sel == 8) begin
			if ($urandom_range(0, 1) == 0)
				edge_val = floor_sub(lane_bud[ln], lane_cnt[ln]);
			else
				edge_val = floor_sub(floor_sub(lim, clamp_add(g_total, lane_cnt[ln])),
					floor_sub(g_resv, lane_bud[ln]));
			return clamp_add(edge_val, $urandom_range(0, 1));
		end
		return ($urandom_range(0, 1) == 0) ? 32'd0 : ALL_ONES;
	endfunction

	// Result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 32'd0, m_tdata[32:1]);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[0] !== want.accepted)
					report_mismatch("accepted", {31'd0, want.accepted},
						{31'd0, m_tdata[0]});
				if (m_tdata[32:1] !== want.total)
					report_mismatch("total", want.total, m_tdata[32:1]);
			end
		end
	end

	// Watchdog on cycles with no transaction on any port
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver: stall pattern of its own, plus one long hold-off to back up the input
	initial begin
		int mode, len;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(10, 80);
			repeat (len) begin
				@(posedge clk);
				if (!held && n_items >= 400) begin
					held = 1;
					m_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end else begin
					case (mode)
						0: m_tready <= 1'b1;
						1: m_tready <= 1'($urandom_range(0, 1));
						2: m_tready <= ($urandom_range(0, 3) != 0);
						default: m_tready <= ($urandom_range(0, 7) == 0);
					endcase
				end
			end
		end
	end

	// Stimulus
	initial begin
		result_t typed;
		row_t row;
		logic [31:0] lim_pick;
		logic op;
		logic [1:0] ln;

		directed_rows = '{
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_READ, 2'd0, 32'd0,         1'b1, 1'b1, 32'd0},
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_ADD,  2'd0, ALL_ONES,      1'b1, 1'b0, 32'd0},
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_ADD,  2'd1, 32'd0,         1'b1, 1'b1, 32'd0},
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_ADD,  2'd0, 32'd100,       1'b0, 1'b0, 32'd0},
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_ADD,  2'd0, 32'd1,         1'b0, 1'b0, 32'd0},
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_ADD,  2'd1, 32'h8000_0000, 1'b0, 1'b0, 32'd0},
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_READ, 2'd3, 32'd0,         1'b0, 1'b0, 32'd0},
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_ADD,  2'd2, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'd0},
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_ADD,  2'd3, 32'h5555_5555, 1'b0, 1'b0, 32'd0},
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_READ, 2'd2, ALL_ONES,      1'b0, 1'b0, 32'd0},
			// zero lanes divides as one
			'{ROW_CFG,  REG_ACTIVE_LANES, OP_ADD, 2'd0, 32'd0,         1'b0, 1'b0, 32'd0},
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_ADD,  2'd2, 32'd1000,      1'b0, 1'b0, 32'd0},
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_ADD,  2'd2, 32'h0FFF_FFFF, 1'b0, 1'b0, 32'd0},
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_READ, 2'd0, 32'd0,         1'b0, 1'b0, 32'd0},
			// limit below the count: headroom clamps to zero
			'{ROW_CFG,  REG_COUNT_LIMIT, OP_ADD,  2'd0, 32'd0,         1'b0, 1'b0, 32'd0},
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_ADD,  2'd1, 32'd1,         1'b1, 1'b0, 32'd0},
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_ADD,  2'd3, 32'd0,         1'b1, 1'b1, 32'd0},
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_READ, 2'd1, 32'd0,         1'b0, 1'b0, 32'd0},
			'{ROW_CFG,  REG_COUNT_LIMIT, OP_ADD,  2'd0, ALL_ONES,      1'b0, 1'b0, 32'd0},
			'{ROW_CFG,  REG_ACTIVE_LANES, OP_ADD, 2'd0, 32'd7,         1'b0, 1'b0, 32'd0},
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_ADD,  2'd0, ALL_ONES,      1'b0, 1'b0, 32'd0},
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_ADD,  2'd1, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'd0},
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_READ, 2'd0, 32'd0,         1'b0, 1'b0, 32'd0},
			'{ROW_CFG,  REG_ACTIVE_LANES, OP_ADD, 2'd0, 32'd1,         1'b0, 1'b0, 32'd0},
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_ADD,  2'd2, 32'h4000_0000, 1'b0, 1'b0, 32'd0},
			'{ROW_ITEM, REG_COUNT_LIMIT, OP_READ, 2'd0, 32'd0,         1'b0, 1'b0, 32'd0}
		};

		// reset state of the predictor
		lim = LIMIT_RESET;
		div_lanes = ACTIVE_RESET;
		for (int i = 0; i < NUM_LANES; i++) begin
			lane_cnt[i] = '0;
			lane_bud[i] = '0;
		end
		g_total = '0;
		g_resv = '0;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int k = 0; k < DIRECTED_N; k++) begin
			row = directed_rows[k];
			if (row.kind == ROW_CFG) begin
				write_reg(row.addr, row.value);
			end else begin
				typed.accepted = row.exp_acc;
				typed.total = row.exp_total;
				send_item(row.op, row.lane, row.value, row.has_exp, typed);
				pace();
			end
		end

		// random phases, each under its own limit and lane divisor
		typed = '0;
		for (int p = 0; p < PHASES; p++) begin
			case ($urandom_range(0, 5))
				0: lim_pick = 32'd0;
				1: lim_pick = $urandom_range(1, 5000);
				2: lim_pick = $urandom;
				3: lim_pick = ALL_ONES;
				4: lim_pick = LIMIT_RESET;
				default: lim_pick = $urandom_range(100000, 50000000);
			endcase
			if (p == 0)
				lim_pick = ALL_ONES;
			write_reg(REG_COUNT_LIMIT, lim_pick);
			write_reg(REG_ACTIVE_LANES, (p == 1) ? 32'd4 : $urandom_range(0, 7));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				op = ($urandom_range(0, 99) < 15) ? OP_READ : OP_ADD;
				ln = 2'($urandom_range(0, NUM_LANES - 1));
				send_item(op, ln, (op == OP_READ) ? $urandom : pick_delta(ln), 1'b0, typed);
				pace();
			end
		end

		// drain
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d transactions: %0d reads, %0d in-budget adds,",
			n_items, n_reads, n_fast);
		$display("%0d refills, %0d rejects; %0d results checked over %0d limit settings",
			n_refill, n_reject, n_results, PHASES + 3);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
